[src/crvu_pkg.sv]
// ----------------------------------------------------------------------------
// crvu_pkg
// Shared types, constants and checksum functions for the configuration
// record validate and update block.
// ----------------------------------------------------------------------------
package crvu_pkg;

	// Item command codes
	typedef enum logic {
		CMD_BYTE   = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRC     = 3'd4;

	// Checksum constants
	localparam logic [7:0]  CRC8_INIT    = 8'hFF;
	localparam logic [7:0]  CRC8_POLY    = 8'h07;
	localparam logic [31:0] CRC32_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC32_POLY   = 32'hEDB8_8320;

	// Record version codes
	localparam logic [7:0] VERSION_BLANK = 8'hFF;
	localparam logic [7:0] VERSION_ONE   = 8'd1;
	localparam logic [7:0] VERSION_TWO   = 8'd2;

	// Queue depths between front and back, and at the result side
	localparam int MQ_DEPTH = 4;
	localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
	localparam int MQ_CNT_W = MQ_PTR_W + 1;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	// Finished table handed from front to back
	typedef struct packed {
		logic [7:0] hash;
		logic [7:0] count;
	} job_t;

	// Resulting record and its status
	typedef struct packed {
		logic [7:0] version;
		logic [7:0] hash;
		logic [7:0] count;
		logic [7:0] pad;
		logic       write_needed;
		logic       was_valid;
	} record_t;

	// Record as queued for the result side
	typedef struct packed {
		record_t     rec;
		logic [31:0] crc;
	} result_t;

	// CRC-8, poly 0x07, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC8_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Reflected CRC-32 over four bytes, b0 first
	function automatic logic [31:0] crc32_four(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		logic [31:0] c;
		logic [31:0] data;
		c = CRC32_INIT;
		data = {b3, b2, b1, b0};
		for (int i = 0; i < 4; i++) begin
			c = c ^ {24'd0, data[8*i +: 8]};
			for (int j = 0; j < 8; j++) begin
				if (c[0]) begin
					c = {1'b0, c[31:1]} ^ CRC32_POLY;
				end else begin
					c = {1'b0, c[31:1]};
				end
			end
		end
		return ~c;
	endfunction

endpackage

[src/crvu_front.sv]
// ----------------------------------------------------------------------------
// crvu_front
// Accepts items, folds table bytes into the running CRC-8 and queues each
// finished table (hash and count) for the back end.
// ----------------------------------------------------------------------------
module crvu_front import crvu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       cmd,
	input  logic [7:0] table_byte,
	input  logic [7:0] sensor_count,
	output job_t       job,
	output logic       job_valid,
	input  logic       job_pop
);

	logic [7:0]          crc8_q;
	job_t                mq_mem_q [MQ_DEPTH];
	logic [MQ_PTR_W-1:0] mq_wr_q;
	logic [MQ_PTR_W-1:0] mq_rd_q;
	logic [MQ_CNT_W-1:0] mq_cnt_q;
	logic                take;
	logic                take_finish;
	logic                take_byte;
	logic                give;

	// Classify the accepted item
	assign full        = (mq_cnt_q == MQ_CNT_W'(MQ_DEPTH));
	assign take        = push && !full;
	assign take_finish = take && (cmd == CMD_FINISH);
	assign take_byte   = take && (cmd == CMD_BYTE);
	assign give        = job_pop && job_valid;

	// Advance the running CRC-8; restart it on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc8_q <= CRC8_INIT;
		end else if (take_finish) begin
			crc8_q <= CRC8_INIT;
		end else if (take_byte) begin
			crc8_q <= crc8_byte(crc8_q, table_byte);
		end
	end

	// Store finished tables
	always_ff @(posedge clk) begin
		if (take_finish) begin
			mq_mem_q[mq_wr_q] <= '{hash: crc8_q ^ sensor_count, count: sensor_count};
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wr_q  <= '0;
			mq_rd_q  <= '0;
			mq_cnt_q <= '0;
		end else begin
			if (take_finish) begin
				mq_wr_q <= mq_wr_q + MQ_PTR_W'(1);
			end
			if (give) begin
				mq_rd_q <= mq_rd_q + MQ_PTR_W'(1);
			end
			if (take_finish && !give) begin
				mq_cnt_q <= mq_cnt_q + MQ_CNT_W'(1);
			end else if (give && !take_finish) begin
				mq_cnt_q <= mq_cnt_q - MQ_CNT_W'(1);
			end
		end
	end

	assign job_valid = (mq_cnt_q != '0);
	assign job       = mq_mem_q[mq_rd_q];

`ifndef SYNTH
	a_mq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mq_cnt_q <= MQ_CNT_W'(MQ_DEPTH))
		else $error("mid queue overfilled");
	a_finish_queued: assert property (@(posedge clk) disable iff (!arst_n)
		take_finish |=> mq_cnt_q != '0)
		else $error("finished table not queued");
	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take_finish |=> crc8_q == CRC8_INIT)
		else $error("running CRC not restarted on finish");
`endif

endmodule

[src/crvu_back.sv]
// ----------------------------------------------------------------------------
// crvu_back
// Holds the stored record, checks it against its CRC-32, decides the new
// record for each finished table and queues the result with its CRC-32.
// ----------------------------------------------------------------------------
module crvu_back import crvu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  job_t                 job,
	input  logic                 job_valid,
	output logic                 job_pop,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result
);

	logic [7:0]          st_version_q;
	logic [7:0]          st_hash_q;
	logic [7:0]          st_count_q;
	logic [7:0]          st_pad_q;
	logic [31:0]         st_crc_q;
	logic [31:0]         st_crc_calc;
	logic                st_valid;
	logic                changed;
	record_t             rec_next;
	record_t             rec_s1;
	logic                valid_s1;
	result_t             oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic [OQ_CNT_W:0]   slots_used;
	logic                oq_take;

	// Load the stored record registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_version_q <= VERSION_BLANK;
			st_hash_q    <= 8'hFF;
			st_count_q   <= 8'hFF;
			st_pad_q     <= 8'hFF;
			st_crc_q     <= CRC32_INIT;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_VERSION: st_version_q <= cfg_wdata[7:0];
				REG_HASH:    st_hash_q    <= cfg_wdata[7:0];
				REG_COUNT:   st_count_q   <= cfg_wdata[7:0];
				REG_PAD:     st_pad_q     <= cfg_wdata[7:0];
				REG_CRC:     st_crc_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Take a job only when the result queue has a slot for it
	assign slots_used = {1'b0, oq_cnt_q} + (OQ_CNT_W+1)'(valid_s1);
	assign job_pop    = job_valid && (slots_used < (OQ_CNT_W+1)'(OQ_DEPTH));

	// Check the stored record and decide the new one
	always_comb begin
		st_crc_calc = crc32_four(st_version_q, st_hash_q, st_count_q, st_pad_q);
		st_valid    = (st_version_q != VERSION_BLANK) && (st_crc_calc == st_crc_q);
		changed     = (st_hash_q != job.hash) || (st_count_q != job.count);
		rec_next.pad       = st_pad_q;
		rec_next.was_valid = st_valid;
		if (!st_valid) begin
			rec_next.version      = VERSION_ONE;
			rec_next.hash         = job.hash;
			rec_next.count        = job.count;
			rec_next.write_needed = 1'b1;
		end else if (changed) begin
			rec_next.version      = (st_version_q == VERSION_ONE) ? VERSION_TWO : VERSION_ONE;
			rec_next.hash         = job.hash;
			rec_next.count        = job.count;
			rec_next.write_needed = 1'b1;
		end else begin
			rec_next.version      = st_version_q;
			rec_next.hash         = st_hash_q;
			rec_next.count        = st_count_q;
			rec_next.write_needed = 1'b0;
		end
	end

	// Decision stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= job_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			rec_s1 <= rec_next;
		end
	end

	// Seal the record with its CRC-32 into the result queue
	assign oq_take = valid_s1;

	always_ff @(posedge clk) begin
		if (oq_take) begin
			oq_mem_q[oq_wr_q] <= '{rec: rec_s1,
				crc: crc32_four(rec_s1.version, rec_s1.hash, rec_s1.count, rec_s1.pad)};
		end
	end

	assign empty  = (oq_cnt_q == '0);
	assign result = oq_mem_q[oq_rd_q];

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_take) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (pop && !empty) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			if (oq_take && !(pop && !empty)) begin
				oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
			end else if ((pop && !empty) && !oq_take) begin
				oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_oq_credit: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used <= (OQ_CNT_W+1)'(OQ_DEPTH))
		else $error("result queue overcommitted");
	a_invalid_rewrites: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rec_s1.was_valid |-> rec_s1.write_needed && rec_s1.version == VERSION_ONE)
		else $error("invalid record not rebuilt as version one");
	a_keep_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rec_s1.write_needed |-> rec_s1.was_valid)
		else $error("invalid record left unwritten");
	a_job_lands: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> valid_s1)
		else $error("popped job lost before decision stage");
`endif

endmodule

[src/config_record_validate_update.sv]
// ----------------------------------------------------------------------------
// config_record_validate_update
// Running CRC-8 over sensor table bytes; on finish, checks the stored record
// and emits the updated record with its CRC-32 and a rewrite flag.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while full is low, table bytes and finishes
// alike. A finish item passes through the mid queue, the decision stage and
// the result queue before it shows on the result ports.
// Reset: arst_n clears the running CRC-8 to 0xFF, the stored record
// registers to all ones and both queues to empty; no clearing pass.
module config_record_validate_update import crvu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  cmd,
	input  logic [7:0]            table_byte,
	input  logic [7:0]            sensor_count,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            new_version,
	output logic [7:0]            new_hash,
	output logic [7:0]            new_count,
	output logic [7:0]            new_pad,
	output logic [31:0]           new_crc,
	output logic                  write_needed,
	output logic                  record_was_valid,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	job_t    job;
	logic    job_valid;
	logic    job_pop;
	result_t result;

	// Front: accept and classify items
	crvu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.table_byte   (table_byte),
		.sensor_count (sensor_count),
		.job          (job),
		.job_valid    (job_valid),
		.job_pop      (job_pop)
	);

	// Back: evaluate the record and queue results
	crvu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.job       (job),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// Unpack the oldest result
	assign new_version      = result.rec.version;
	assign new_hash         = result.rec.hash;
	assign new_count        = result.rec.count;
	assign new_pad          = result.rec.pad;
	assign new_crc          = result.crc;
	assign write_needed     = result.rec.write_needed;
	assign record_was_valid = result.rec.was_valid;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for config_record_validate_update. Sensor table bytes
// and finish items go in through the push side. A local model keeps the
// running CRC-8 and the stored record registers, and predicts every record
// that comes out of the pop side. Both sides idle at random. One stretch
// holds the result side off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import crvu_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int RX_HOLD     = 300;
	localparam int ITEM_TARGET = 750;

	typedef struct {
		cmd_t       op;
		logic [7:0] data;
		logic [7:0] count;
	} table_item_t;

	// DUT connections
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  cmd = 1'b0;
	logic [7:0]            table_byte = '0;
	logic [7:0]            sensor_count = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            new_version;
	logic [7:0]            new_hash;
	logic [7:0]            new_count;
	logic [7:0]            new_pad;
	logic [31:0]           new_crc;
	logic                  write_needed;
	logic                  record_was_valid;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Model state: stored record registers and the running table CRC
	logic [7:0]  store_version = VERSION_BLANK;
	logic [7:0]  store_hash = 8'hFF;
	logic [7:0]  store_count = 8'hFF;
	logic [7:0]  store_pad = 8'hFF;
	logic [31:0] store_crc = CRC32_INIT;
	logic [7:0]  table_crc = CRC8_INIT;

	table_item_t pending_items[$];
	result_t     expected_records[$];

	// Table under construction, and a copy kept for replay
	logic [7:0] staged_table[$];
	logic [7:0] staged_count;
	logic [7:0] saved_table[$];
	logic [7:0] saved_count;

	bit gaps_on = 1'b1;
	bit rx_stall_armed = 1'b0;
	bit rx_stall_taken = 1'b0;
	int rx_stall_left = 0;
	int fail_count = 0;
	int items_queued = 0;
	int items_accepted = 0;
	int records_checked = 0;
	int rewrites = 0;
	int valid_stores = 0;
	int quiet_cycles = 0;

	config_record_validate_update dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.cmd              (cmd),
		.table_byte       (table_byte),
		.sensor_count     (sensor_count),
		.empty            (empty),
		.pop              (pop),
		.new_version      (new_version),
		.new_hash         (new_hash),
		.new_count        (new_count),
		.new_pad          (new_pad),
		.new_crc          (new_crc),
		.write_needed     (write_needed),
		.record_was_valid (record_was_valid),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// CRC-8, poly 0x07, fed one data bit at a time from the top
	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			c = (c[7] ^ b[i]) ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// Reflected CRC-32 over version, hash, count, pad, fed bit-serially
	function automatic logic [31:0] record_crc32(input logic [7:0] v, h, n, p);
		logic [31:0] c;
		logic [31:0] stream;
		c = CRC32_INIT;
		stream = {p, n, h, v};
		for (int i = 0; i < 32; i++) begin
			c = (c[0] ^ stream[i]) ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

	// Advance the table CRC, or on a finish work out the record to expect
	task automatic predict_record(input table_item_t it);
		logic [7:0] hash;
		bit         valid;
		result_t    r;
		if (it.op == CMD_BYTE) begin
			table_crc = crc8_next(table_crc, it.data);
			return;
		end
		hash = table_crc ^ it.count;
		table_crc = CRC8_INIT;
		valid = (store_version != VERSION_BLANK) &&
			(record_crc32(store_version, store_hash, store_count, store_pad) == store_crc);
		r.rec.version = store_version;
		r.rec.hash = store_hash;
		r.rec.count = store_count;
		r.rec.pad = store_pad;
		r.rec.write_needed = 1'b0;
		r.rec.was_valid = valid;
		if (!valid || store_hash != hash || store_count != it.count) begin
			if (!valid) begin
				r.rec.version = VERSION_ONE;
			end else begin
				r.rec.version = (store_version == VERSION_ONE) ? VERSION_TWO : VERSION_ONE;
			end
			r.rec.hash = hash;
			r.rec.count = it.count;
			r.rec.write_needed = 1'b1;
		end
		r.crc = record_crc32(r.rec.version, r.rec.hash, r.rec.count, r.rec.pad);
		expected_records.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compare the record on the result ports with the oldest expectation
	task automatic check_record();
		result_t want;
		if (expected_records.size() == 0) begin
			$display("%t: record with nothing expected, expected none, got version %0h hash %0h",
				$time, new_version, new_hash);
			fail_count++;
			return;
		end
		want = expected_records.pop_front();
		check_field("new_version", 32'(want.rec.version), 32'(new_version));
		check_field("new_hash", 32'(want.rec.hash), 32'(new_hash));
		check_field("new_count", 32'(want.rec.count), 32'(new_count));
		check_field("new_pad", 32'(want.rec.pad), 32'(new_pad));
		check_field("new_crc", want.crc, new_crc);
		check_field("write_needed", 32'(want.rec.write_needed), 32'(write_needed));
		check_field("record_was_valid", 32'(want.rec.was_valid), 32'(record_was_valid));
		records_checked++;
		rewrites += int'(want.rec.write_needed);
		valid_stores += int'(want.rec.was_valid);
	endtask

	// Driver: offer items from the pending queue, hold while the block is full
	always @(posedge clk) begin
		bit offer;
		if (arst_n) begin
			if (push && !full) begin
				predict_record(pending_items.pop_front());
				items_accepted++;
			end
			if (!(push && full)) begin
				offer = (pending_items.size() != 0) && !(gaps_on && $urandom_range(99) < 12);
				push <= offer;
				if (offer) begin
					cmd <= pending_items[0].op;
					table_byte <= pending_items[0].data;
					sensor_count <= pending_items[0].count;
				end
			end
		end
	end

	// Monitor: check each popped record; take the long hold-off once when armed
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				check_record();
			end
			if (rx_stall_armed && !rx_stall_taken) begin
				rx_stall_left = RX_HOLD;
				rx_stall_taken = 1'b1;
			end
			if (rx_stall_left != 0) begin
				rx_stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= !(gaps_on && $urandom_range(99) < 12);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_VERSION: store_version = data[7:0];
			REG_HASH:    store_hash = data[7:0];
			REG_COUNT:   store_count = data[7:0];
			REG_PAD:     store_pad = data[7:0];
			REG_CRC:     store_crc = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Load a whole record; a bad one gets a single flipped checksum bit
	task automatic store_record(input logic [7:0] ver, h, n, p, input bit good);
		logic [31:0] word;
		word = record_crc32(ver, h, n, p);
		if (!good) begin
			word ^= 32'h1 << $urandom_range(31);
		end
		write_reg(REG_VERSION, {24'($urandom), ver});
		write_reg(REG_HASH, {24'($urandom), h});
		write_reg(REG_COUNT, {24'($urandom), n});
		write_reg(REG_PAD, {24'($urandom), p});
		write_reg(REG_CRC, word);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		pending_items.push_back('{CMD_BYTE, b, 8'($urandom)});
		items_queued++;
	endtask

	task automatic queue_finish(input logic [7:0] n);
		pending_items.push_back('{CMD_FINISH, 8'($urandom), n});
		items_queued++;
	endtask

	task automatic random_table(input int max_len);
		int len;
		len = $urandom_range(max_len, 0);
		staged_table.delete();
		repeat (len) staged_table.push_back(8'($urandom));
		staged_count = 8'($urandom);
	endtask

	function automatic logic [7:0] staged_hash();
		logic [7:0] c;
		c = CRC8_INIT;
		foreach (staged_table[i]) c = crc8_next(c, staged_table[i]);
		return c ^ staged_count;
	endfunction

	task automatic queue_staged();
		foreach (staged_table[i]) queue_byte(staged_table[i]);
		queue_finish(staged_count);
	endtask

	function automatic logic [7:0] pick_version();
		case ($urandom_range(3))
			0: return VERSION_ONE;
			1: return VERSION_TWO;
			2: return 8'($urandom_range(254));
			default: return 8'h00;
		endcase
	endfunction

	// Wait until the block has drained, then let the pipeline settle
	task automatic settle();
		while (pending_items.size() != 0 || expected_records.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		int phase_no;
		int mode;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Blank store after reset: empty tables at both count extremes, then extreme bytes
		queue_finish(8'h00);
		queue_finish(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h80);
		queue_byte(8'h7F);
		queue_finish(8'hA5);
		settle();

		// Valid version one record matching the next table, then a changed count
		random_table(6);
		store_record(VERSION_ONE, staged_hash(), staged_count, 8'h00, 1'b1);
		for (int i = int'(REG_CRC) + 1; i < 2 ** CFG_IDX_W; i++) begin
			write_reg(CFG_IDX_W'(i), $urandom);
		end
		queue_staged();
		queue_finish(staged_count ^ 8'h01);
		settle();

		// Version two toggles back to one
		store_record(VERSION_TWO, 8'($urandom), 8'($urandom), 8'hFF, 1'b1);
		queue_finish(8'($urandom));
		settle();

		// Any other valid version also becomes one
		store_record(8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		queue_finish(8'($urandom));
		settle();

		// Blank version with a correct checksum is still invalid
		store_record(VERSION_BLANK, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		queue_finish(8'($urandom));
		settle();

		// Zeroed checksum word
		store_record(VERSION_ONE, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		write_reg(REG_CRC, 32'h0);
		queue_finish(8'($urandom));
		settle();

		// Random phases: one store setting each, then a run of whole tables
		phase_no = 0;
		while (items_queued < ITEM_TARGET) begin
			mode = $urandom_range(5);
			random_table(12);
			saved_table = staged_table;
			saved_count = staged_count;
			case (mode)
				0, 1: store_record(pick_version(), staged_hash(), staged_count, 8'($urandom), 1'b1);
				2: store_record(pick_version(), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
				3: store_record(pick_version(), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
				4: store_record(VERSION_BLANK, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
				default: begin
					write_reg(REG_VERSION, $urandom);
					write_reg(REG_HASH, $urandom);
					write_reg(REG_COUNT, $urandom);
					write_reg(REG_PAD, $urandom);
					write_reg(REG_CRC, $urandom);
				end
			endcase
			if (phase_no == 4) begin
				// Hold the result side off with no idling, so the block backs up
				gaps_on = 1'b0;
				rx_stall_armed = 1'b1;
				repeat (40) begin
					random_table(2);
					queue_staged();
				end
			end else begin
				repeat (8) begin
					if (mode <= 1 && $urandom_range(2) == 0) begin
						staged_table = saved_table;
						staged_count = saved_count;
					end else begin
						random_table(12);
					end
					queue_staged();
				end
			end
			settle();
			gaps_on = 1'b1;
			phase_no++;
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d items over %0d store settings; checked %0d records.",
			items_accepted, phase_no + 6, records_checked);
		$display("Records: %0d rewritten, %0d left as stored, %0d from a valid store.",
			rewrites, records_checked - rewrites, valid_stores);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
src/crvu_pkg.sv
src/crvu_front.sv
src/crvu_back.sv
src/config_record_validate_update.sv
dv/tb.sv
